/* rtl/depth_limited_route_search_unit_macros.svh */
// Assertion helpers used by the checker.
`ifndef DEPTH_LIMITED_ROUTE_SEARCH_UNIT_MACROS_SVH
`define DEPTH_LIMITED_ROUTE_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DLRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlrs assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DLRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlrs assertion failed");

`endif

/* rtl/dlrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dlrs_pkg;

    localparam int NUM_ROOMS = 32;
    localparam int NUM_DOORS = 4;

    // Fixed field widths of the request and result items.
    localparam int ROOM_W = 5;
    localparam int DOOR_W = 2;
    localparam int STEP_W = 2;

    localparam int LVL_W     = $clog2(NUM_DOORS);
    localparam int CUR_W     = $clog2(NUM_DOORS + 1);
    localparam int TBL_DEPTH = NUM_ROOMS * NUM_DOORS;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int TBL_W     = ROOM_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_EVAL,
        ST_FAIL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic write_door;
        logic capture;
        logic init;
        logic issue;
        logic pop;
        logic eval;
        logic emit_nf;
        logic emit_path;
    } t_cmd;

    typedef struct packed {
        logic start_ok;
        logic cursor_done;
        logic level_one;
        logic cand_hit;
        logic out_free;
        logic emit_last;
    } t_stat;

    function automatic logic room_ok(input logic [ROOM_W-1:0] room);
        room_ok = (32'(room) < NUM_ROOMS);
    endfunction

    function automatic logic [ADDR_W-1:0] door_addr(input int unsigned room,
                                                    input int unsigned door);
        door_addr = ADDR_W'(room * NUM_DOORS + door);
    endfunction

endpackage

`default_nettype wire

/* rtl/dlrs_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/dlrs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlrs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_command,
    input  wire dlrs_pkg::t_stat i_stat,
    output      logic            o_in_ready,
    output      dlrs_pkg::t_cmd  o_cmd
);

    dlrs_pkg::t_state r_state;
    dlrs_pkg::t_state n_state;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == dlrs_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dlrs_pkg::ST_IDLE: begin
                if (w_accept && i_in_command) begin
                    n_state = dlrs_pkg::ST_START;
                end
            end
            dlrs_pkg::ST_START: begin
                if (i_stat.start_ok) begin
                    n_state = dlrs_pkg::ST_CHECK;
                end else begin
                    n_state = dlrs_pkg::ST_FAIL;
                end
            end
            dlrs_pkg::ST_CHECK: begin
                if (!i_stat.cursor_done) begin
                    n_state = dlrs_pkg::ST_EVAL;
                end else if (i_stat.level_one) begin
                    n_state = dlrs_pkg::ST_FAIL;
                end
            end
            dlrs_pkg::ST_EVAL: begin
                if (i_stat.cand_hit) begin
                    n_state = dlrs_pkg::ST_EMIT;
                end else begin
                    n_state = dlrs_pkg::ST_CHECK;
                end
            end
            dlrs_pkg::ST_FAIL: begin
                if (i_stat.out_free) begin
                    n_state = dlrs_pkg::ST_IDLE;
                end
            end
            dlrs_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = dlrs_pkg::ST_IDLE;
                end
            end
            default: n_state = dlrs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dlrs_pkg::ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.write_door = w_accept && !i_in_command;
                o_cmd.capture    = w_accept && i_in_command;
            end
            dlrs_pkg::ST_START: o_cmd.init = i_stat.start_ok;
            dlrs_pkg::ST_CHECK: begin
                o_cmd.issue = !i_stat.cursor_done;
                o_cmd.pop   = i_stat.cursor_done;
            end
            dlrs_pkg::ST_EVAL:  o_cmd.eval      = 1'b1;
            dlrs_pkg::ST_FAIL:  o_cmd.emit_nf   = i_stat.out_free;
            dlrs_pkg::ST_EMIT:  o_cmd.emit_path = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/dlrs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module dlrs_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dlrs_pkg::t_cmd                i_cmd,
    input  wire logic [dlrs_pkg::ROOM_W-1:0]   i_room_index,
    input  wire logic [dlrs_pkg::DOOR_W-1:0]   i_door_index,
    input  wire logic [dlrs_pkg::ROOM_W-1:0]   i_door_target,
    input  wire logic                          i_door_open,
    input  wire logic [dlrs_pkg::ROOM_W-1:0]   i_start_room,
    input  wire logic [dlrs_pkg::ROOM_W-1:0]   i_end_room,
    input  wire logic                          i_out_ready,
    output      dlrs_pkg::t_stat               o_stat,
    output      logic                          o_out_valid,
    output      logic [dlrs_pkg::STEP_W-1:0]   o_path_step,
    output      logic [dlrs_pkg::ROOM_W-1:0]   o_path_room,
    output      logic                          o_found,
    output      logic                          o_last
);

    localparam int ND  = dlrs_pkg::NUM_DOORS;
    localparam int RW  = dlrs_pkg::ROOM_W;
    localparam int LW  = dlrs_pkg::LVL_W;
    localparam int CW  = dlrs_pkg::CUR_W;
    localparam int AW  = dlrs_pkg::ADDR_W;
    localparam int TD  = dlrs_pkg::TBL_DEPTH;

    logic [RW-1:0] r_start, n_start;
    logic [RW-1:0] r_end, n_end;
    logic [RW-1:0] r_path [ND];
    logic [RW-1:0] n_path [ND];
    logic [CW-1:0] r_cursor [ND];
    logic [CW-1:0] n_cursor [ND];
    logic [LW-1:0] r_level, n_level;
    logic [LW-1:0] r_k, n_k;
    logic [LW-1:0] r_last_k, n_last_k;
    logic          r_set [TD];
    logic          n_set [TD];
    logic          r_rd_set;
    logic          r_out_valid, n_out_valid;
    logic [dlrs_pkg::STEP_W-1:0] r_out_step, n_out_step;
    logic [RW-1:0] r_out_room, n_out_room;
    logic          r_out_found, n_out_found;
    logic          r_out_last, n_out_last;

    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;
    logic                         w_load_ok;
    logic [dlrs_pkg::TBL_W-1:0]   w_rdata;
    logic [RW-1:0]                w_target;
    logic                         w_on_path;
    logic                         w_cand_ok;
    logic                         w_cand_hit;
    logic [LW-1:0]                w_prev;

    assign w_waddr   = dlrs_pkg::door_addr(32'(i_room_index), 32'(i_door_index));
    assign w_load_ok = dlrs_pkg::room_ok(i_room_index) && (32'(i_door_index) < ND);
    assign w_prev    = LW'(r_level - 1'b1);
    assign w_raddr   = dlrs_pkg::door_addr(32'(r_path[w_prev]), 32'(r_cursor[r_level]));

    dlrs_ram #(
        .WIDTH (dlrs_pkg::TBL_W),
        .DEPTH (TD)
    ) u_door_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_door && w_load_ok),
        .i_waddr (w_waddr),
        .i_wdata ({i_door_target, i_door_open}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A door never written since reset reads as closed.
    assign w_target = w_rdata[dlrs_pkg::TBL_W-1:1];

    always_comb begin
        w_on_path = 1'b0;
        for (int i = 0; i < ND; i++) begin
            if ((LW'(i) < r_level) && (r_path[i] == w_target)) begin
                w_on_path = 1'b1;
            end
        end
    end

    assign w_cand_ok  = r_rd_set && w_rdata[0] && dlrs_pkg::room_ok(w_target) && !w_on_path;
    assign w_cand_hit = w_cand_ok && (w_target == r_end);

    always_comb begin
        o_stat.start_ok    = dlrs_pkg::room_ok(r_start);
        o_stat.cursor_done = (32'(r_cursor[r_level]) >= ND);
        o_stat.level_one   = (r_level == LW'(1));
        o_stat.cand_hit    = w_cand_hit;
        o_stat.out_free    = !r_out_valid || i_out_ready;
        o_stat.emit_last   = (r_k == r_last_k);
    end

    always_comb begin
        n_start     = r_start;
        n_end       = r_end;
        n_path      = r_path;
        n_cursor    = r_cursor;
        n_level     = r_level;
        n_k         = r_k;
        n_last_k    = r_last_k;
        n_set       = r_set;
        n_out_valid = r_out_valid;
        n_out_step  = r_out_step;
        n_out_room  = r_out_room;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;

        if (i_cmd.write_door && w_load_ok) begin
            n_set[w_waddr] = 1'b1;
        end
        if (i_cmd.capture) begin
            n_start = i_start_room;
            n_end   = i_end_room;
        end
        if (i_cmd.init) begin
            n_path[0]   = r_start;
            n_level     = LW'(1);
            n_cursor[1] = '0;
            n_k         = '0;
        end
        if (i_cmd.issue) begin
            n_cursor[r_level] = CW'(r_cursor[r_level] + 1'b1);
        end
        if (i_cmd.pop) begin
            n_level = w_prev;
        end
        // Take the door's target; descend unless it is the goal or the path is full.
        if (i_cmd.eval && w_cand_ok) begin
            n_path[r_level] = w_target;
            if (w_cand_hit) begin
                n_last_k = r_level;
            end else if (r_level != LW'(ND - 1)) begin
                n_level                     = LW'(r_level + 1'b1);
                n_cursor[LW'(r_level + 1'b1)] = '0;
            end
        end

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit_nf) begin
            n_out_valid = 1'b1;
            n_out_step  = '0;
            n_out_room  = '0;
            n_out_found = 1'b0;
            n_out_last  = 1'b1;
        end
        if (i_cmd.emit_path) begin
            n_out_valid = 1'b1;
            n_out_step  = dlrs_pkg::STEP_W'(r_k);
            n_out_room  = r_path[r_k];
            n_out_found = 1'b1;
            n_out_last  = (r_k == r_last_k);
            n_k         = LW'(r_k + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= '0;
            r_k         <= '0;
            r_last_k    <= '0;
            r_cursor    <= '{default: '0};
            r_set       <= '{default: 1'b0};
            r_rd_set    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_level     <= n_level;
            r_k         <= n_k;
            r_last_k    <= n_last_k;
            r_cursor    <= n_cursor;
            r_set       <= n_set;
            r_rd_set    <= r_set[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_end       <= n_end;
        r_path      <= n_path;
        r_out_step  <= n_out_step;
        r_out_room  <= n_out_room;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_path_step = r_out_step;
    assign o_path_room = r_out_room;
    assign o_found     = r_out_found;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

/* rtl/depth_limited_route_search_unit.sv */
// Door load: no result; the request side stays ready, so the next request is taken the cycle after.
// Route search: accept, set up, then for each door tried a door table read and then a test,
// and a backtrack step when a level has no doors left; the result register then sends one
// room per cycle while the receiver is ready.
// Reset (synchronous, active low) clears controller, output valid and door written flags.
`timescale 1ns / 1ps
`default_nettype none

module depth_limited_route_search_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // tdata: room_index[4:0], door_index[6:5], door_target[11:7], door_open[12],
    //        start_room[17:13], end_room[22:18], zero pad[23]
    input  wire logic [23:0] s_axis_tdata,
    // tuser: command[0] (0 load a door, 1 search a route)
    input  wire logic        s_axis_tuser,
    // result side
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: path_step[1:0], path_room[6:2], zero pad[7]
    output      logic [7:0]  m_axis_tdata,
    // tuser: found[0]
    output      logic        m_axis_tuser,
    // tlast: last result of this search
    output      logic        m_axis_tlast
);

    dlrs_pkg::t_cmd  w_cmd;
    dlrs_pkg::t_stat w_stat;

    logic [dlrs_pkg::STEP_W-1:0] w_path_step;
    logic [dlrs_pkg::ROOM_W-1:0] w_path_room;

    // The controller sequences the search; it sees only status flags from the datapath.
    dlrs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_command (s_axis_tuser),
        .i_stat       (w_stat),
        .o_in_ready   (s_axis_tready),
        .o_cmd        (w_cmd)
    );

    // The datapath holds the door table, the path and cursor stacks and the result register.
    dlrs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_room_index  (s_axis_tdata[4:0]),
        .i_door_index  (s_axis_tdata[6:5]),
        .i_door_target (s_axis_tdata[11:7]),
        .i_door_open   (s_axis_tdata[12]),
        .i_start_room  (s_axis_tdata[17:13]),
        .i_end_room    (s_axis_tdata[22:18]),
        .i_out_ready   (m_axis_tready),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .o_path_step   (w_path_step),
        .o_path_room   (w_path_room),
        .o_found       (m_axis_tuser),
        .o_last        (m_axis_tlast)
    );

    // Pack the result fields, lowest first; pad the top bit with zero.
    assign m_axis_tdata = {1'b0, w_path_room, w_path_step};

endmodule

`default_nettype wire

/* rtl/dlrs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "depth_limited_route_search_unit_macros.svh"

module dlrs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       s_axis_tuser,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // Hold a stalled result.
    `DLRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // A not-found result is a lone, zero result.
    `DLRS_ASSERT_SAME(a_nf_shape, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata == 8'd0))

    // A route request closes the request side while the search runs.
    `DLRS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready)

endmodule

bind depth_limited_route_search_unit dlrs_checker u_dlrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
